@@ src/cow_extent_overlay_resolver_assert.svh @@
// assertion macros for the extent overlay resolver
`ifndef COW_EXTENT_OVERLAY_RESOLVER_ASSERT_SVH
`define COW_EXTENT_OVERLAY_RESOLVER_ASSERT_SVH

// a condition holds whenever out of reset
`define COW_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// an antecedent implies a consequent in the next cycle
`define COW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cow_pkg.sv @@
package cow_pkg;

    localparam int MaxExtentsDefault = 16;
    localparam int OffW = 40;
    localparam int LenW = 21;
    localparam int InnerW = 20;
    localparam logic [LenW-1:0] LenLimit = 21'd1048576;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [2:0] ST_RECORDED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BACKING  = 3'd2;
    localparam logic [2:0] ST_EXTENT   = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic            command;
        logic [OffW-1:0] offset;
        logic [LenW-1:0] length;
    } cow_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        extent_slot;
        logic [OffW-1:0]   segment_address;
        logic [InnerW-1:0] inner_offset;
        logic [LenW-1:0]   segment_length;
        logic              last;
    } cow_rsp_t;

    // classified request passed from front to back
    typedef struct packed {
        logic            command;
        logic [OffW-1:0] offset;
        logic [LenW-1:0] length;
    } cow_job_t;

endpackage

@@ src/cow_front.sv @@
module cow_front (
    input  logic              clk,
    input  logic              rst_n,
    input  cow_pkg::cow_req_t req,
    input  logic              req_valid,
    output logic              req_ready,
    output cow_pkg::cow_job_t job,
    output logic              job_valid,
    input  logic              job_ready
);
    import cow_pkg::*;

    // two entry queue
    cow_job_t   q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cow_job_t   cls;
    logic       push, pop;

    // saturate length on entry
    always_comb
    begin
        cls.command = req.command;
        cls.offset  = req.offset;
        cls.length  = (req.length > LenLimit) ? LenLimit : req.length;
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];
    assign push      = req_valid && req_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/cow_back.sv @@
module cow_back #(
    parameter int MAX_EXTENTS = cow_pkg::MaxExtentsDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cow_pkg::cow_job_t job,
    input  logic              job_valid,
    output logic              job_ready,
    output cow_pkg::cow_rsp_t rsp,
    output logic              rsp_valid,
    input  logic              rsp_ready
);
    import cow_pkg::*;

    localparam int IdxW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CntW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_EXTENTS);

    typedef enum logic [2:0] {S_IDLE, S_HIT, S_CUT, S_EMIT, S_WAIT} state_t;

    logic [OffW-1:0] st_mem [MAX_EXTENTS];
    logic [LenW-1:0] sz_mem [MAX_EXTENTS];

    state_t          state_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] i_reg;
    logic [OffW:0]   pos_reg;
    logic [LenW-1:0] rem_reg, lim_reg;
    logic            hit_reg;
    logic [IdxW-1:0] hidx_reg;
    logic [OffW-1:0] hstart_reg;
    logic            rv_reg, rv_next;
    cow_rsp_t        rsp_reg;

    logic [IdxW-1:0] ri;
    logic [OffW-1:0] s_rd;
    logic [LenW-1:0] z_rd;
    logic [OffW:0]   e_rd;
    logic            covers;
    logic [OffW:0]   avail;
    logic [OffW:0]   dlt;
    logic            cut;
    logic [OffW:0]   inner;
    logic [CntW-1:0] lo;
    logic            emit_go;
    logic            load_rsp;
    cow_rsp_t        idle_rsp;
    cow_rsp_t        emit_rsp;

    assign ri      = i_reg[IdxW-1:0] - 1'b1;
    assign s_rd    = st_mem[ri];
    assign z_rd    = sz_mem[ri];
    assign e_rd    = {1'b0, s_rd} + (OffW+1)'(z_rd);
    assign covers  = ({1'b0, s_rd} <= pos_reg) && (pos_reg < e_rd);
    assign avail   = e_rd - pos_reg;
    assign dlt     = {1'b0, s_rd} - pos_reg;
    assign cut     = (z_rd != '0) && ({1'b0, s_rd} > pos_reg)
                     && (dlt < (OffW+1)'(lim_reg));
    assign inner   = pos_reg - {1'b0, hstart_reg};
    assign lo      = hit_reg ? (CntW'(hidx_reg) + 1'b1) : '0;

    assign job_ready = (state_reg == S_IDLE) && !rv_reg;
    assign rsp       = rsp_reg;
    assign rsp_valid = rv_reg;

    // single result for a write or an empty read
    always_comb
    begin
        idle_rsp                 = '0;
        idle_rsp.segment_address = job.offset;
        idle_rsp.last            = 1'b1;
        if (job.command == CMD_WRITE)
        begin
            if (count_reg < MaxCnt)
            begin
                idle_rsp.status      = ST_RECORDED;
                idle_rsp.extent_slot = 4'(count_reg);
            end
            else
            begin
                idle_rsp.status = ST_FULL;
            end
        end
        else
        begin
            idle_rsp.status = ST_EMPTY;
        end
    end

    // segment result
    always_comb
    begin
        emit_rsp                 = '0;
        emit_rsp.status          = hit_reg ? ST_EXTENT : ST_BACKING;
        emit_rsp.extent_slot     = hit_reg ? 4'(hidx_reg) : 4'd0;
        emit_rsp.segment_address = pos_reg[OffW-1:0];
        emit_rsp.inner_offset    = hit_reg ? inner[InnerW-1:0] : '0;
        emit_rsp.segment_length  = lim_reg;
        emit_rsp.last            = (rem_reg == lim_reg);
    end

    // result valid tracking
    always_comb
    begin
        emit_go  = !rv_reg || rsp_ready;
        load_rsp = ((state_reg == S_IDLE) && job_valid && job_ready
                    && (job.command == CMD_WRITE || job.length == '0))
                   || ((state_reg == S_EMIT) && emit_go);
        rv_next  = load_rsp || (rv_reg && !rsp_ready);
    end

    // extent table write
    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready && job.command == CMD_WRITE && count_reg < MaxCnt)
        begin
            st_mem[count_reg[IdxW-1:0]] <= job.offset;
            sz_mem[count_reg[IdxW-1:0]] <= job.length;
        end
    end

    // sequencer: hit scan newest first, then cut scan, then emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            i_reg      <= '0;
            pos_reg    <= '0;
            rem_reg    <= '0;
            lim_reg    <= '0;
            hit_reg    <= 1'b0;
            hidx_reg   <= '0;
            hstart_reg <= '0;
            rv_reg     <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            rv_reg <= rv_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        if (job.command == CMD_WRITE)
                        begin
                            rsp_reg <= idle_rsp;
                            if (count_reg < MaxCnt)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        else if (job.length == '0)
                        begin
                            rsp_reg <= idle_rsp;
                        end
                        else
                        begin
                            pos_reg   <= {1'b0, job.offset};
                            rem_reg   <= job.length;
                            lim_reg   <= job.length;
                            hit_reg   <= 1'b0;
                            i_reg     <= count_reg;
                            state_reg <= S_HIT;
                        end
                    end
                end
                S_HIT:
                begin
                    if (i_reg == '0)
                    begin
                        i_reg     <= count_reg;
                        state_reg <= S_CUT;
                    end
                    else if (covers)
                    begin
                        hit_reg    <= 1'b1;
                        hidx_reg   <= ri;
                        hstart_reg <= s_rd;
                        if (avail < (OffW+1)'(lim_reg))
                        begin
                            lim_reg <= LenW'(avail);
                        end
                        i_reg     <= count_reg;
                        state_reg <= S_CUT;
                    end
                    else
                    begin
                        i_reg <= i_reg - 1'b1;
                    end
                end
                S_CUT:
                begin
                    if (i_reg <= lo)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        if (cut)
                        begin
                            lim_reg <= LenW'(dlt);
                        end
                        i_reg <= i_reg - 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        rsp_reg   <= emit_rsp;
                        pos_reg   <= pos_reg + (OffW+1)'(lim_reg);
                        rem_reg   <= rem_reg - lim_reg;
                        lim_reg   <= rem_reg - lim_reg;
                        hit_reg   <= 1'b0;
                        i_reg     <= count_reg;
                        state_reg <= (rem_reg == lim_reg) ? S_WAIT : S_HIT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/cow_extent_overlay_resolver.sv @@
// a write or empty read result is loaded into the result register when its job is taken
// each read segment is resolved by a hit scan and then a cut scan over the recorded extents
// (both over one table read port), then emitted
// the back end takes no new request while a result is still waiting to be accepted
// a two entry request queue lets requests be taken while the back end works
// rst_n clears queue, extent count and control; extent table contents stay undefined
module cow_extent_overlay_resolver #(
    parameter int MAX_EXTENTS = cow_pkg::MaxExtentsDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cow_pkg::cow_req_t in_data,
    input  logic              in_valid,
    output logic              in_ready,
    output cow_pkg::cow_rsp_t out_data,
    output logic              out_valid,
    input  logic              out_ready
);
    import cow_pkg::*;

    `include "cow_extent_overlay_resolver_assert.svh"

    cow_job_t job;
    logic     job_valid, job_ready;

    cow_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (in_data),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    cow_back #(.MAX_EXTENTS(MAX_EXTENTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .rsp       (out_data),
        .rsp_valid (out_valid),
        .rsp_ready (out_ready)
    );

    // shorthands for the checks
    logic [2:0]      rsp_status;
    logic [LenW-1:0] rsp_len;
    logic            rsp_seg;
    logic            stalled;

    assign rsp_status = out_data.status;
    assign rsp_len    = out_data.segment_length;
    assign rsp_seg    = (rsp_status == ST_BACKING) || (rsp_status == ST_EXTENT);
    assign stalled    = out_valid && !out_ready;

    `COW_ASSERT_ALWAYS(a_status_range, clk, rst_n, !out_valid || rsp_status <= ST_EMPTY, "bad status")
    `COW_ASSERT_ALWAYS(a_empty_len, clk, rst_n, !out_valid || rsp_seg || rsp_len == '0, "nonzero length")
    `COW_ASSERT_ALWAYS(a_seg_len, clk, rst_n, !out_valid || !rsp_seg || rsp_len != '0, "empty segment")
    `COW_ASSERT_NEXT(a_hold, clk, rst_n, stalled, out_valid && $stable(out_data), "held result changed")

endmodule
